FILE: rtl/ile_pkg.sv
// shared types and constants of the indexed list engine
package ile_pkg;

    // default configuration
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // fixed port field widths
    localparam int MODE_BITS   = 3;
    localparam int POS_BITS    = 6;
    localparam int DATA_BITS   = 32;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;

    // operation codes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_APPEND = 3'd0,
        MODE_GET    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_SET    = 3'd3,
        MODE_POP    = 3'd4,
        MODE_REMOVE = 3'd5
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic write_en;
        logic shift_up;
        logic shift_down;
        logic read_en;
    } cell_ctl_t;

endpackage

FILE: rtl/ile_cell.sv
// one list entry cell: holds a word and trades it with its neighbors
module ile_cell #(
    parameter int WORD_BITS = ile_pkg::WORD_BITS_DEF,
    parameter int IDX_W     = 6,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  ile_pkg::cell_ctl_t    ctl,
    input  logic [IDX_W-1:0]      target,
    input  logic [WORD_BITS-1:0]  word,
    input  logic [WORD_BITS-1:0]  left_value,
    input  logic [WORD_BITS-1:0]  right_value,
    output logic [WORD_BITS-1:0]  value,
    output logic [WORD_BITS-1:0]  read_value
);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;
    logic                 hit;
    logic                 above;

    assign hit   = (target == IDX_W'(INDEX));
    assign above = (IDX_W'(INDEX) > target);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_up)
        begin
            // insert: cells past the target take the lower neighbor
            if (above)
            begin
                entry_next = left_value;
            end
            else if (hit)
            begin
                entry_next = word;
            end
        end
        else if (ctl.shift_down)
        begin
            // remove: target and later cells take the upper neighbor
            if (hit || above)
            begin
                entry_next = right_value;
            end
        end
        else if (ctl.write_en && hit)
        begin
            entry_next = word;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value      = entry_reg;
    assign read_value = (ctl.read_en && hit) ? entry_reg : '0;

endmodule

FILE: rtl/indexed_list_engine_unit.sv
// indexed list engine: ordered word list held in a row of shifting cells
// the result is registered: it becomes valid in the cycle after the input transaction is accepted
// throughput: one transaction per cycle while the result side is not stalled, every cell updates in the same cycle
// the per-operation path is count check, cell update and a one-hot read select
// reset: count and the result valid flag clear, result payload and entries keep their values
// entries at or above the count are never read, so they need no clearing
module indexed_list_engine_unit #(
    parameter int DEPTH     = ile_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ile_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ile_pkg::MODE_BITS-1:0]    mode,
    input  logic [ile_pkg::POS_BITS-1:0]     position,
    input  logic [ile_pkg::DATA_BITS-1:0]    word_in,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ile_pkg::DATA_BITS-1:0]    word_out,
    output logic [ile_pkg::COUNT_BITS-1:0]   entry_count,
    output logic [ile_pkg::STATUS_BITS-1:0]  status
);

    // count holds 0..DEPTH, an index 0..DEPTH-1
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    // common width for comparing the request position against the count
    localparam int CMP_W = (CNT_W > ile_pkg::POS_BITS) ? CNT_W : ile_pkg::POS_BITS;

    // list state
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // result register, parts the request side from the result side
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [WORD_BITS-1:0]      word_out_reg;
    logic [CNT_W-1:0]          entry_count_reg;
    ile_pkg::status_t          status_reg;

    // decode of the current transaction
    logic                      in_fire;
    logic                      full;
    logic                      empty;
    logic                      out_of_range;
    ile_pkg::status_t          status_next;
    ile_pkg::cell_ctl_t        ctl;
    logic [IDX_W-1:0]          target;
    logic [WORD_BITS-1:0]      word_ext;
    logic [WORD_BITS-1:0]      read_word;

    // cell row wiring
    logic [WORD_BITS-1:0]      cell_value [DEPTH];
    logic [WORD_BITS-1:0]      cell_read  [DEPTH];

    // a new transaction enters whenever the result slot is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign full         = (count_reg == CNT_W'(DEPTH));
    assign empty        = (count_reg == '0);
    assign out_of_range = (CMP_W'(position) >= CMP_W'(count_reg));
    assign word_ext     = WORD_BITS'(word_in);

    // status, count update and the command for the cell row
    always_comb
    begin
        status_next = ile_pkg::ST_OK;
        count_next  = count_reg;
        ctl         = '0;
        target      = IDX_W'(position);
        case (ile_pkg::mode_t'(mode))
            ile_pkg::MODE_APPEND:
            begin
                target = IDX_W'(count_reg);
                if (full)
                begin
                    status_next = ile_pkg::ST_FULL;
                end
                else
                begin
                    ctl.write_en = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            ile_pkg::MODE_GET:
            begin
                if (out_of_range)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.read_en = 1'b1;
                end
            end
            ile_pkg::MODE_INSERT:
            begin
                // full list is checked before the index
                if (full)
                begin
                    status_next = ile_pkg::ST_FULL;
                end
                else if (out_of_range)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.shift_up = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            ile_pkg::MODE_SET:
            begin
                if (out_of_range)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.write_en = 1'b1;
                end
            end
            ile_pkg::MODE_POP:
            begin
                target = IDX_W'(count_reg - CNT_W'(1));
                if (empty)
                begin
                    status_next = ile_pkg::ST_EMPTY;
                end
                else
                begin
                    ctl.read_en = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            ile_pkg::MODE_REMOVE:
            begin
                if (out_of_range)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.shift_down = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // unused codes: no operation, ok status
                status_next = ile_pkg::ST_OK;
            end
        endcase
        // cells only move on an accepted transaction
        if (!in_fire)
        begin
            ctl = '0;
        end
    end

    // the row of cells: each sees its lower and upper neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_value;
        logic [WORD_BITS-1:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_left
            assign left_value = cell_value[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_right
            assign right_value = cell_value[g+1];
        end

        ile_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX_W     (IDX_W),
            .INDEX     (g)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .target      (target),
            .word        (word_ext),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[g]),
            .read_value  (cell_read[g])
        );
    end

    // at most one cell drives its word, the rest give zero
    always_comb
    begin
        read_word = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            read_word = read_word | cell_read[k];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_out_reg    <= read_word;
            entry_count_reg <= count_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_out    = ile_pkg::DATA_BITS'(word_out_reg);
    assign entry_count = ile_pkg::COUNT_BITS'(entry_count_reg);
    assign status      = status_reg;

    // the count never passes the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count beyond depth");

    // a failed transaction leaves the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (status_next != ile_pkg::ST_OK) |=> count_reg == $past(count_reg))
        else $error("failed operation changed the count");

    // a successful append grows the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (ile_pkg::mode_t'(mode) == ile_pkg::MODE_APPEND) && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the list");

    // a pending result reports the count the list now holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> entry_count_reg == count_reg)
        else $error("result count disagrees with list state");

endmodule

FILE: tb/indexed_list_engine_unit_tb.sv
// self-checking testbench of the indexed list engine: directed and random operation streams
module indexed_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int LIST_DEPTH    = DEPTH_DEF;
    localparam int RUN_ITEMS     = 750;       // random operations after the directed part
    localparam int CYCLE_LIMIT   = 400000;    // far above the slowest legal run
    localparam int SETTLE_CYCLES = 5;         // covers the result register plus margin
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_HOLD     = 150;       // receiver hold-off that backs up the request side
    localparam int BACKLOG_MARK  = 125;       // sender waits for an empty pipe this often

    // the two unused operation codes; the block must answer them with a plain ok
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [DATA_BITS-1:0] WORD_ONES     = '1;

    // one request transaction as queued for the driver
    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [POS_BITS-1:0]  position;
        logic [DATA_BITS-1:0] word_in;
        logic                 wait_idle;   // hold this one back until every result is home
    } list_req_t;

    // one result transaction
    typedef struct packed {
        logic [DATA_BITS-1:0]   word_out;
        logic [COUNT_BITS-1:0]  entry_count;
        logic [STATUS_BITS-1:0] status;
    } list_resp_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [MODE_BITS-1:0]   mode        = '0;
    logic [POS_BITS-1:0]    position    = '0;
    logic [DATA_BITS-1:0]   word_in     = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [DATA_BITS-1:0]   word_out;
    logic [COUNT_BITS-1:0]  entry_count;
    logic [STATUS_BITS-1:0] status;

    // pending requests, filled once before reset and drained by the driver
    list_req_t  req_backlog[$];
    // results the list should produce, oldest first
    list_resp_t list_expect[$];

    // shadow copy of the list held by the predictor
    logic [DATA_BITS-1:0] list_words [LIST_DEPTH];
    int                   list_len   = 0;
    int                   list_peak  = 0;

    // entry count as the stimulus builder sees it, used only to shape the streams
    int gen_len = 0;

    int total_reqs    = 0;
    int req_accepted  = 0;
    int resp_seen     = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int op_tally      [8];
    int status_tally  [4];

    // driver and receiver bookkeeping
    logic      req_taken   = 1'b0;
    list_req_t cur_req;
    int        send_gap    = 0;
    int        send_style  = 1;
    int        stall_left  = 0;
    int        recv_style  = 1;
    int        hold_left   = 0;
    int        hold_count  = 0;

    list_req_t  seen_req;
    list_resp_t got_resp;
    list_resp_t want_resp;

    indexed_list_engine_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .position    (position),
        .word_in     (word_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_out    (word_out),
        .entry_count (entry_count),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // list behavior: applies one operation to the shadow list and returns its result
    function automatic list_resp_t predict_list_op(input list_req_t r);
        list_resp_t e;
        int         p;
        e.word_out = '0;
        e.status   = ST_OK;
        p          = r.position;
        case (r.mode)
            MODE_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    e.status = ST_FULL;
                else
                begin
                    list_words[list_len] = r.word_in;
                    list_len++;
                end
            end
            MODE_GET:
            begin
                if (p >= list_len)
                    e.status = ST_RANGE;
                else
                    e.word_out = list_words[p];
            end
            MODE_INSERT:
            begin
                // fullness wins over a bad index
                if (list_len >= LIST_DEPTH)
                    e.status = ST_FULL;
                else if (p >= list_len)
                    e.status = ST_RANGE;
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = r.word_in;
                    list_len++;
                end
            end
            MODE_SET:
            begin
                if (p >= list_len)
                    e.status = ST_RANGE;
                else
                    list_words[p] = r.word_in;
            end
            MODE_POP:
            begin
                if (list_len == 0)
                    e.status = ST_EMPTY;
                else
                begin
                    list_len--;
                    e.word_out = list_words[list_len];
                end
            end
            MODE_REMOVE:
            begin
                if (p >= list_len)
                    e.status = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        e.entry_count = list_len[COUNT_BITS-1:0];
        return e;
    endfunction

    // queue one request and track the entry count it will leave behind
    task automatic queue_op(input logic [MODE_BITS-1:0] m, input logic [POS_BITS-1:0] p,
                            input logic [DATA_BITS-1:0] w, input logic idle_first);
        list_req_t r;
        r = '{mode: m, position: p, word_in: w, wait_idle: idle_first};
        req_backlog.push_back(r);
        case (m)
            MODE_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
            MODE_INSERT: if (gen_len < LIST_DEPTH && p < gen_len) gen_len++;
            MODE_POP:    if (gen_len > 0) gen_len--;
            MODE_REMOVE: if (p < gen_len) gen_len--;
            default:     ;
        endcase
    endtask

    // data words lean toward the all-zero and all-one corners
    function automatic logic [DATA_BITS-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return WORD_ONES;
        return $urandom;
    endfunction

    // mostly valid indexes, some right at the count, some anywhere
    function automatic logic [POS_BITS-1:0] pick_pos();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (gen_len > 0 && roll < 16)
            return POS_BITS'($urandom_range(0, gen_len - 1));
        if (roll < 18 && gen_len < LIST_DEPTH)
            return POS_BITS'(gen_len);
        return POS_BITS'($urandom_range(0, LIST_DEPTH - 1));
    endfunction

    // idle length: style 0 never idles, style 1 short gaps, style 2 allows long ones
    function automatic int pick_gap(input int style);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (style == 0 || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, (style == 2) ? 40 : 15);
    endfunction

    task automatic build_stimulus();
        int                   done_items;
        int                   linger;
        int unsigned          roll;
        logic                 filling;
        logic [MODE_BITS-1:0] op;

        // every indexed operation, a pop and both spare codes on the empty list
        queue_op(MODE_POP,      6'd0,  '0,         1'b0);
        queue_op(MODE_GET,      6'd0,  '0,         1'b0);
        queue_op(MODE_INSERT,   6'd0,  WORD_ONES,  1'b0);
        queue_op(MODE_SET,      6'd0,  WORD_ONES,  1'b0);
        queue_op(MODE_REMOVE,   6'd0,  '0,         1'b0);
        queue_op(MODE_SPARE_LO, 6'd63, WORD_ONES,  1'b0);
        queue_op(MODE_SPARE_HI, 6'd63, WORD_ONES,  1'b0);
        // small list, reads at both ends and just past the end
        queue_op(MODE_APPEND,   6'd0,  WORD_ONES,          1'b0);
        queue_op(MODE_APPEND,   6'd63, '0,                 1'b0);
        queue_op(MODE_APPEND,   6'd0,  32'h5A5A_5A5A,      1'b0);
        queue_op(MODE_GET,      6'd0,  '0,                 1'b0);
        queue_op(MODE_GET,      6'd2,  '0,                 1'b0);
        queue_op(MODE_GET,      6'd3,  '0,                 1'b0);
        // insert at the head, at the count (refused) and in the middle
        queue_op(MODE_INSERT,   6'd0,  32'h1234_5678,      1'b0);
        queue_op(MODE_INSERT,   6'd4,  32'hFFFF_0000,      1'b0);
        queue_op(MODE_INSERT,   6'd1,  32'h8000_0001,      1'b0);
        queue_op(MODE_SET,      6'd4,  32'hDEAD_BEEF,      1'b0);
        queue_op(MODE_SET,      6'd5,  32'h0000_FFFF,      1'b0);
        // remove at head and at tail, then empty it out
        queue_op(MODE_REMOVE,   6'd0,  '0,                 1'b0);
        queue_op(MODE_REMOVE,   6'd3,  '0,                 1'b0);
        queue_op(MODE_GET,      6'd63, '0,                 1'b0);
        queue_op(MODE_POP,      6'd0,  '0,                 1'b0);
        queue_op(MODE_POP,      6'd0,  '0,                 1'b0);
        queue_op(MODE_POP,      6'd0,  '0,                 1'b0);
        queue_op(MODE_POP,      6'd0,  '0,                 1'b0);

        // random part swings between filling to full and draining to empty
        done_items = 0;
        linger     = 0;
        filling    = 1'b1;
        while (done_items < RUN_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                queue_op(roll[0] ? MODE_SPARE_HI : MODE_SPARE_LO, POS_BITS'($urandom),
                         $urandom, 1'b0);
                continue;
            end
            if (filling)
                op = (roll < 40) ? MODE_APPEND : (roll < 68) ? MODE_INSERT :
                     (roll < 80) ? MODE_GET    : (roll < 90) ? MODE_SET    :
                     (roll < 95) ? MODE_REMOVE : MODE_POP;
            else
                op = (roll < 35) ? MODE_POP    : (roll < 65) ? MODE_REMOVE :
                     (roll < 78) ? MODE_GET    : (roll < 90) ? MODE_SET    :
                     (roll < 95) ? MODE_APPEND : MODE_INSERT;
            queue_op(op, pick_pos(), pick_word(), (done_items % BACKLOG_MARK) == BACKLOG_MARK - 1);
            done_items++;

            // stay a few operations at full or empty before turning around
            if (linger > 0)
            begin
                linger--;
                if (linger == 0)
                    filling = !filling;
            end
            else if ((filling && gen_len == LIST_DEPTH) || (!filling && gen_len == 0))
                linger = $urandom_range(2, 6);
            else if ($urandom_range(0, 199) == 0)
                filling = !filling;
        end
    endtask

    // request driver: new payload on the falling edge, held until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !req_taken)
        begin
            // still waiting for the block to take it
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (req_backlog.size() > 0 &&
                 !(req_backlog[0].wait_idle && list_expect.size() > 0))
        begin
            cur_req   = req_backlog.pop_front();
            mode     <= cur_req.mode;
            position <= cur_req.position;
            word_in  <= cur_req.word_in;
            in_valid <= 1'b1;
            // during a receiver hold-off keep pushing so the block backs up
            send_gap <= (hold_left > 0) ? 0 : pick_gap(send_style);
            if ($urandom_range(0, 39) == 0)
                send_style <= $urandom_range(0, 2);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls plus two long hold-offs at fixed points in the run
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_count < 2 && req_accepted >= ((hold_count == 0) ? 200 : 560))
        begin
            out_ready  <= 1'b0;
            hold_left  <= LONG_HOLD - 1;
            hold_count <= hold_count + 1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= pick_gap(recv_style);
            if ($urandom_range(0, 49) == 0)
                recv_style <= $urandom_range(0, 2);
        end
    end

    // monitor: predict on each accepted request, compare each accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen_req = '{mode: mode, position: position, word_in: word_in, wait_idle: 1'b0};
                want_resp = predict_list_op(seen_req);
                list_expect.push_back(want_resp);
                req_accepted++;
                op_tally[mode]++;
                status_tally[want_resp.status]++;
                if (list_len > list_peak)
                    list_peak = list_len;
            end
            if (out_valid && out_ready)
            begin
                resp_seen++;
                got_resp = '{word_out: word_out, entry_count: entry_count, status: status};
                if (list_expect.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("cycle %0d: result transaction with nothing expected: %h %0d %0d",
                                 cycle_count, word_out, entry_count, status);
                end
                else
                begin
                    want_resp = list_expect.pop_front();
                    if (got_resp.word_out !== want_resp.word_out ||
                        got_resp.entry_count !== want_resp.entry_count ||
                        got_resp.status !== want_resp.status)
                    begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                            $display("cycle %0d: mismatch word_out %h exp %h, ",
                                     cycle_count, got_resp.word_out, want_resp.word_out,
                                     "entry_count %0d exp %0d, ",
                                     got_resp.entry_count, want_resp.entry_count,
                                     "status %0d exp %0d",
                                     got_resp.status, want_resp.status);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        foreach (op_tally[i])
            op_tally[i] = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        build_stimulus();
        total_reqs = req_backlog.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every request answered, then a few quiet cycles to catch stray results
        wait (resp_seen >= total_reqs);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (list_expect.size() != 0)
        begin
            err_count += list_expect.size();
            $display("%0d expected result transactions never arrived", list_expect.size());
        end

        $display("covered %0d transactions: append %0d get %0d insert %0d",
                 req_accepted, op_tally[MODE_APPEND], op_tally[MODE_GET],
                 op_tally[MODE_INSERT],
                 " set %0d pop %0d remove %0d spare %0d",
                 op_tally[MODE_SET], op_tally[MODE_POP], op_tally[MODE_REMOVE],
                 op_tally[MODE_SPARE_LO] + op_tally[MODE_SPARE_HI]);
        $display("status ok %0d range %0d empty %0d full %0d, longest list %0d entries",
                 status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_EMPTY],
                 status_tally[ST_FULL], list_peak);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine_unit.sv
tb/indexed_list_engine_unit_tb.sv
